// File: rtl/sps_pkg.sv
// Shared constants, request and result codes, and control/status bundles.
`timescale 1ns / 1ps
package sps_pkg;

	// Timer clock and derived divider sizes
	localparam int unsigned TIMER_TICK_HZ = 1000000;
	localparam int unsigned DIV_BITS      = $clog2(TIMER_TICK_HZ + 1);
	localparam int unsigned DIV_CNT_W     = $clog2(DIV_BITS);
	localparam int unsigned HP_W          = 19;
	localparam logic [HP_W-1:0] HP_MAX    = {HP_W{1'b1}};
	localparam logic [DIV_BITS-1:0] DIV_NUM = DIV_BITS'(TIMER_TICK_HZ);
	localparam logic [HP_W-1:0] HP_RESET  = HP_W'(TIMER_TICK_HZ / 1000);

	// Request codes
	localparam logic [3:0] REQ_START_FIN = 4'd0;
	localparam logic [3:0] REQ_START_LIM = 4'd1;
	localparam logic [3:0] REQ_NAP       = 4'd2;
	localparam logic [3:0] REQ_STOP      = 4'd3;
	localparam logic [3:0] REQ_CLEAR     = 4'd4;
	localparam logic [3:0] REQ_RELEASE   = 4'd5;
	localparam logic [3:0] REQ_HOLD      = 4'd6;
	localparam logic [3:0] REQ_POLL      = 4'd7;
	localparam logic [3:0] REQ_TICK      = 4'd8;

	// Motion phase codes
	localparam logic [2:0] PH_IDLE    = 3'd0;
	localparam logic [2:0] PH_DIRWAIT = 3'd1;
	localparam logic [2:0] PH_RUN     = 3'd2;
	localparam logic [2:0] PH_HOLD    = 3'd3;
	localparam logic [2:0] PH_FAULT   = 3'd4;

	// Stop reasons
	localparam logic [2:0] SR_NONE      = 3'd0;
	localparam logic [2:0] SR_DONE      = 3'd1;
	localparam logic [2:0] SR_EXPECTED  = 3'd2;
	localparam logic [2:0] SR_FAULT     = 3'd3;
	localparam logic [2:0] SR_MISMATCH  = 3'd4;
	localparam logic [2:0] SR_REQUESTED = 3'd5;

	// Start status
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_PARAM   = 3'd1;
	localparam logic [2:0] ST_BUSY    = 3'd2;
	localparam logic [2:0] ST_INFAULT = 3'd3;
	localparam logic [2:0] ST_BLOCKED = 3'd4;

	// Raised errors
	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_UPPER    = 2'd1;
	localparam logic [1:0] ERR_LOWER    = 2'd2;
	localparam logic [1:0] ERR_MISMATCH = 2'd3;

	// Configuration register indexes
	localparam logic [1:0] CFG_MAX_FREQ  = 2'd0;
	localparam logic [1:0] CFG_AUTO_FREQ = 2'd1;
	localparam logic [1:0] CFG_NAP_MAX   = 2'd2;
	localparam logic [1:0] CFG_SETUP_MS  = 2'd3;

	// Controller to datapath commands
	typedef struct packed {
		logic start;
		logic expect_limit;
		logic stop;
		logic timer_clr;
		logic tick_clr;
		logic tick_inc;
		logic step_set;
		logic step_clr;
		logic done_inc;
		logic expect_clr;
		logic hold_arm;
		logic hold_clr;
		logic rel_set;
		logic rel_clr;
		logic div_step;
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic       param_bad;
		logic [1:0] filt_start;
		logic [1:0] filt_run;
		logic       dir_reached;
		logic       hold_armed;
		logic       hold_reached;
		logic       tick_hit;
		logic       raw_mismatch;
		logic       raw_hit;
		logic       done_ge_target;
		logic       step_active;
		logic       expect_limit;
		logic       dir_up;
		logic       div_last;
	} dp_stat_t;

endpackage

// File: rtl/sps_datapath.sv
// Datapath: configuration, counters, timestamps and the half-period divider.
`timescale 1ns / 1ps
module sps_datapath import sps_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata,
	input  logic [3:0]  req_type,
	input  logic        move_up,
	input  logic [15:0] pulse_count,
	input  logic [15:0] step_freq_hz,
	input  logic [31:0] now_ms,
	input  logic [3:0]  raw_limits,
	input  logic        filtered_mismatch,
	input  logic        blocked_up,
	input  logic        blocked_down,
	input  dp_cmd_t     cmd,
	output dp_stat_t    stat,
	output logic        step_d,
	output logic        dir_d,
	output logic        rel_d,
	output logic [15:0] done_d
);

	logic [15:0] max_freq_q, auto_freq_q, nap_max_q;
	logic [7:0]  setup_ms_q;

	logic            dir_q, step_q, exp_q, rel_q, armed_q;
	logic [15:0]     tgt_q, done_q;
	logic [HP_W-1:0] hp_q, tick_q;
	logic [31:0]     ready_q, deadline_q;

	logic            exp_d, armed_d;
	logic [15:0]     tgt_d;
	logic [HP_W-1:0] tick_d;
	logic [31:0]     ready_d, deadline_d;

	logic [15:0] start_freq;
	logic [31:0] now_plus_ms, dir_diff, hold_diff;
	logic [HP_W:0] tick_next;
	logic        lu, ru, ll, rl;

	// Divider state
	logic [16:0]          dvs_q;
	logic [16:0]          rem_q;
	logic [DIV_BITS-1:0]  quo_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [17:0]          rem_sh;
	logic [17:0]          rem_sub;
	logic                 qbit;
	logic [DIV_BITS-1:0]  quo_new;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_freq_q  <= 16'd2000;
			auto_freq_q <= 16'd500;
			nap_max_q   <= 16'd200;
			setup_ms_q  <= 8'd5;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MAX_FREQ:  max_freq_q  <= cfg_wdata;
				CFG_AUTO_FREQ: auto_freq_q <= cfg_wdata;
				CFG_NAP_MAX:   nap_max_q   <= cfg_wdata;
				CFG_SETUP_MS:  setup_ms_q  <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	// Evaluate conditions for the controller
	assign start_freq  = (req_type == REQ_NAP) ? auto_freq_q : step_freq_hz;
	assign now_plus_ms = now_ms + 32'(setup_ms_q);
	assign dir_diff    = now_ms - ready_q;
	assign hold_diff   = now_ms - deadline_q;
	assign tick_next   = {1'b0, tick_q} + 1'b1;
	assign lu = raw_limits[0];
	assign ru = raw_limits[1];
	assign ll = raw_limits[2];
	assign rl = raw_limits[3];

	always_comb begin
		stat.param_bad = (pulse_count == 16'd0) || (start_freq == 16'd0) ||
			(start_freq > max_freq_q) ||
			((req_type == REQ_NAP) && (pulse_count > nap_max_q));
		stat.filt_start = filtered_mismatch ? ERR_MISMATCH :
			(move_up ? (blocked_up ? ERR_UPPER : ERR_NONE)
			         : (blocked_down ? ERR_LOWER : ERR_NONE));
		stat.filt_run = filtered_mismatch ? ERR_MISMATCH :
			(dir_q ? (blocked_up ? ERR_UPPER : ERR_NONE)
			       : (blocked_down ? ERR_LOWER : ERR_NONE));
		stat.dir_reached  = !dir_diff[31];
		stat.hold_armed   = armed_q;
		// An unarmed deadline is now plus the hold time: reached only at zero
		stat.hold_reached = armed_q ? !hold_diff[31] : (setup_ms_q == 8'd0);
		stat.tick_hit     = tick_next >= {1'b0, hp_q};
		stat.raw_mismatch = (lu != ru) || (ll != rl);
		stat.raw_hit      = dir_q ? (lu | ru) : (ll | rl);
		stat.done_ge_target = done_q >= tgt_q;
		stat.step_active  = step_q;
		stat.expect_limit = exp_q;
		stat.dir_up       = dir_q;
		stat.div_last     = (cnt_q == '0);
	end

	// Next values of the motion registers
	always_comb begin
		dir_d      = dir_q;
		step_d     = step_q;
		exp_d      = exp_q;
		rel_d      = rel_q;
		armed_d    = armed_q;
		tgt_d      = tgt_q;
		done_d     = done_q;
		tick_d     = tick_q;
		ready_d    = ready_q;
		deadline_d = deadline_q;
		if (cmd.start) begin
			dir_d   = move_up;
			tgt_d   = pulse_count;
			done_d  = 16'd0;
			tick_d  = '0;
			step_d  = 1'b0;
			exp_d   = cmd.expect_limit;
			armed_d = 1'b0;
			rel_d   = 1'b0;
			ready_d = now_plus_ms;
		end
		if (cmd.stop) begin
			step_d  = 1'b0;
			tick_d  = '0;
			tgt_d   = 16'd0;
			armed_d = 1'b0;
			exp_d   = 1'b0;
		end
		if (cmd.timer_clr) begin
			step_d = 1'b0;
			tick_d = '0;
		end
		if (cmd.tick_clr) tick_d = '0;
		if (cmd.tick_inc) tick_d = tick_next[HP_W-1:0];
		if (cmd.step_set) step_d = 1'b1;
		if (cmd.step_clr) step_d = 1'b0;
		if (cmd.done_inc) done_d = done_q + 16'd1;
		if (cmd.expect_clr) exp_d = 1'b0;
		if (cmd.hold_arm) begin
			armed_d    = 1'b1;
			deadline_d = now_plus_ms;
		end
		if (cmd.hold_clr) armed_d = 1'b0;
		if (cmd.rel_set) rel_d = 1'b1;
		if (cmd.rel_clr) rel_d = 1'b0;
	end

	// Hold motion registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q   <= 1'b1;
			step_q  <= 1'b0;
			exp_q   <= 1'b0;
			rel_q   <= 1'b0;
			armed_q <= 1'b0;
			tgt_q   <= 16'd0;
			done_q  <= 16'd0;
			tick_q  <= '0;
			ready_q <= 32'd0;
		end else begin
			dir_q   <= dir_d;
			step_q  <= step_d;
			exp_q   <= exp_d;
			rel_q   <= rel_d;
			armed_q <= armed_d;
			tgt_q   <= tgt_d;
			done_q  <= done_d;
			tick_q  <= tick_d;
			ready_q <= ready_d;
		end
	end

	always_ff @(posedge clk) begin
		deadline_q <= deadline_d;
	end

	// Restoring divider: one quotient bit per cycle
	assign rem_sh  = {rem_q, quo_q[DIV_BITS-1]};
	assign rem_sub = rem_sh - {1'b0, dvs_q};
	assign qbit    = !rem_sub[17];
	assign quo_new = {quo_q[DIV_BITS-2:0], qbit};

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			dvs_q <= {start_freq, 1'b0};
			rem_q <= 17'd0;
			quo_q <= DIV_NUM;
		end else if (cmd.div_step) begin
			rem_q <= qbit ? rem_sub[16:0] : rem_sh[16:0];
			quo_q <= quo_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			hp_q  <= HP_RESET;
		end else if (cmd.start) begin
			cnt_q <= DIV_CNT_W'(DIV_BITS - 1);
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q - 1'b1;
			// Clamp the half period to one tick up to the counter range
			if (cnt_q == '0) begin
				if (quo_new == '0)
					hp_q <= HP_W'(1);
				else if (quo_new > DIV_BITS'(HP_MAX))
					hp_q <= HP_MAX;
				else
					hp_q <= quo_new[HP_W-1:0];
			end
		end
	end

endmodule

// File: rtl/sps_ctrl.sv
// Controller: motion phase machine, request decoding and divider sequencing.
`timescale 1ns / 1ps
module sps_ctrl import sps_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       acc,
	input  logic [3:0] req_type,
	input  dp_stat_t   stat,
	output dp_cmd_t    cmd,
	output logic       busy,
	output logic [2:0] phase_d,
	output logic [2:0] reason_d,
	output logic [2:0] status_d,
	output logic [1:0] err_d
);

	typedef enum logic {SEQ_READY, SEQ_DIVIDE} seq_t;

	seq_t       seq_q;
	logic [2:0] phase_q, reason_q;

	assign busy = (seq_q == SEQ_DIVIDE);

	// Decode the beat against the current phase
	always_comb begin
		cmd      = '0;
		phase_d  = phase_q;
		reason_d = reason_q;
		status_d = ST_OK;
		err_d    = ERR_NONE;
		cmd.div_step = busy;
		if (acc) begin
			case (req_type)
				REQ_START_FIN, REQ_START_LIM, REQ_NAP: begin
					if (stat.param_bad)
						status_d = ST_PARAM;
					else if (phase_q != PH_IDLE)
						status_d = (phase_q == PH_FAULT) ? ST_INFAULT : ST_BUSY;
					else if (stat.filt_start != ERR_NONE) begin
						err_d    = stat.filt_start;
						phase_d  = PH_FAULT;
						status_d = ST_BLOCKED;
					end else begin
						cmd.start        = 1'b1;
						cmd.expect_limit = (req_type == REQ_START_LIM);
						reason_d         = SR_NONE;
						phase_d          = PH_DIRWAIT;
					end
				end
				REQ_STOP: begin
					cmd.stop = 1'b1;
					phase_d  = PH_IDLE;
					reason_d = SR_REQUESTED;
				end
				REQ_CLEAR: begin
					if (phase_q == PH_FAULT) begin
						cmd.timer_clr = 1'b1;
						phase_d       = PH_IDLE;
						reason_d      = SR_NONE;
					end
				end
				REQ_RELEASE: begin
					cmd.stop    = 1'b1;
					cmd.rel_set = 1'b1;
					phase_d     = PH_IDLE;
					reason_d    = SR_REQUESTED;
				end
				REQ_HOLD: cmd.rel_clr = 1'b1;
				REQ_POLL: begin
					if (phase_q == PH_DIRWAIT) begin
						if (stat.dir_reached) begin
							if (stat.filt_run != ERR_NONE) begin
								err_d   = stat.filt_run;
								phase_d = PH_FAULT;
							end else begin
								cmd.tick_clr = 1'b1;
								phase_d      = PH_RUN;
							end
						end
					end else if (phase_q == PH_HOLD) begin
						if (!stat.hold_armed) cmd.hold_arm = 1'b1;
						if (stat.hold_reached) begin
							cmd.hold_clr = 1'b1;
							phase_d      = PH_IDLE;
						end
					end
				end
				REQ_TICK: begin
					if (phase_q == PH_RUN) begin
						if (!stat.tick_hit)
							cmd.tick_inc = 1'b1;
						else begin
							cmd.tick_clr = 1'b1;
							if (stat.raw_mismatch) begin
								err_d          = ERR_MISMATCH;
								reason_d       = SR_MISMATCH;
								cmd.timer_clr  = 1'b1;
								cmd.expect_clr = 1'b1;
								phase_d        = PH_FAULT;
							end else if (stat.raw_hit) begin
								cmd.timer_clr  = 1'b1;
								cmd.expect_clr = 1'b1;
								if (stat.expect_limit) begin
									reason_d = SR_EXPECTED;
									phase_d  = PH_HOLD;
								end else begin
									err_d    = stat.dir_up ? ERR_UPPER : ERR_LOWER;
									reason_d = SR_FAULT;
									phase_d  = PH_FAULT;
								end
							end else if (!stat.step_active && !stat.done_ge_target) begin
								cmd.step_set = 1'b1;
								cmd.done_inc = 1'b1;
							end else begin
								// Drop the step level; finish once the count is reached
								cmd.step_clr = 1'b1;
								if (stat.done_ge_target) begin
									cmd.timer_clr  = 1'b1;
									cmd.expect_clr = 1'b1;
									reason_d       = SR_DONE;
									phase_d        = PH_HOLD;
								end
							end
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Hold phase, stop reason and sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q    <= SEQ_READY;
			phase_q  <= PH_IDLE;
			reason_q <= SR_NONE;
		end else begin
			phase_q  <= phase_d;
			reason_q <= reason_d;
			unique case (seq_q)
				SEQ_READY:  if (cmd.start) seq_q <= SEQ_DIVIDE;
				SEQ_DIVIDE: if (stat.div_last) seq_q <= SEQ_READY;
				default:    seq_q <= SEQ_READY;
			endcase
		end
	end

endmodule

// File: rtl/stepper_pulse_sequencer_with_limits.sv
// Top level: step/direction sequencer with limit supervision and output register.
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------
//  in       | in_valid/in_stall  | req_type move_up pulse_count ... blocked_down
//  out      | out_valid/out_stall| status step_level ... error_raised
//  cfg      | cfg_we             | cfg_index cfg_wdata
//
// Each beat's result is registered into the output register; one new beat
// per cycle while results are taken. A successful start additionally runs the
// half-period divider over DIV_BITS (20) quotient bits, one quotient bit per cycle,
// during which in_stall is high. in_stall is also high while a result waits
// on out_stall. Reset clears all control state; no clearing pass.
`timescale 1ns / 1ps
module stepper_pulse_sequencer_with_limits import sps_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [3:0]  req_type,
	input  logic        move_up,
	input  logic [15:0] pulse_count,
	input  logic [15:0] step_freq_hz,
	input  logic [31:0] now_ms,
	input  logic [3:0]  raw_limits,
	input  logic        filtered_mismatch,
	input  logic        blocked_up,
	input  logic        blocked_down,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic        step_level,
	output logic        dir_up,
	output logic        motor_released,
	output logic [2:0]  fsm_state,
	output logic [2:0]  stop_reason,
	output logic [15:0] pulses_done,
	output logic [1:0]  error_raised
);

	dp_cmd_t     cmd;
	dp_stat_t    stat;
	logic        acc, busy;
	logic        step_d, dir_d, rel_d;
	logic [15:0] done_d;
	logic [2:0]  phase_d, reason_d, status_d;
	logic [1:0]  err_d;
	logic        out_valid_q;

	assign in_stall  = busy || (out_valid_q && out_stall);
	assign acc       = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	sps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.acc      (acc),
		.req_type (req_type),
		.stat     (stat),
		.cmd      (cmd),
		.busy     (busy),
		.phase_d  (phase_d),
		.reason_d (reason_d),
		.status_d (status_d),
		.err_d    (err_d)
	);

	sps_datapath u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_wdata         (cfg_wdata),
		.req_type          (req_type),
		.move_up           (move_up),
		.pulse_count       (pulse_count),
		.step_freq_hz      (step_freq_hz),
		.now_ms            (now_ms),
		.raw_limits        (raw_limits),
		.filtered_mismatch (filtered_mismatch),
		.blocked_up        (blocked_up),
		.blocked_down      (blocked_down),
		.cmd               (cmd),
		.stat              (stat),
		.step_d            (step_d),
		.dir_d             (dir_d),
		.rel_d             (rel_d),
		.done_d            (done_d)
	);

	// Output beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (acc)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	// Capture the result beat
	always_ff @(posedge clk) begin
		if (acc) begin
			status         <= status_d;
			step_level     <= step_d;
			dir_up         <= dir_d;
			motor_released <= rel_d;
			fsm_state      <= phase_d;
			stop_reason    <= reason_d;
			pulses_done    <= done_d;
			error_raised   <= err_d;
		end
	end

	a_div_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> in_stall)
		else $error("beat accepted during half-period division");

	a_step_only_running: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && step_level) |-> (fsm_state == PH_RUN))
		else $error("step level high outside running");

	a_blocked_raises: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == ST_BLOCKED)) |-> (error_raised != ERR_NONE))
		else $error("blocked start without raised error");

endmodule

// File: test/stepper_pulse_sequencer_with_limits_test.sv
// Self-checking bench for the step/direction pulse sequencer with limit supervision.
`timescale 1ns / 1ps
module stepper_pulse_sequencer_with_limits_test;
	import sps_pkg::*;

	typedef struct packed {
		logic [3:0]  req;
		logic        up;
		logic [15:0] pulses;
		logic [15:0] freq;
		logic [31:0] now;
		logic [3:0]  raw;
		logic        fmis;
		logic        bup;
		logic        bdn;
	} cmd_t;

	typedef struct packed {
		logic [2:0]  status;
		logic        step;
		logic        dir;
		logic        rel;
		logic [2:0]  st;
		logic [2:0]  reason;
		logic [15:0] done;
		logic [1:0]  err;
	} resp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [15:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	cmd_t cur = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [2:0]  o_status, o_state, o_reason;
	logic        o_step, o_dir, o_rel;
	logic [15:0] o_done;
	logic [1:0]  o_err;
	resp_t got;

	stepper_pulse_sequencer_with_limits DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .in_valid(in_valid), .in_stall(in_stall),
		.req_type(cur.req), .move_up(cur.up), .pulse_count(cur.pulses),
		.step_freq_hz(cur.freq), .now_ms(cur.now), .raw_limits(cur.raw),
		.filtered_mismatch(cur.fmis), .blocked_up(cur.bup), .blocked_down(cur.bdn),
		.out_valid(out_valid), .out_stall(out_stall), .status(o_status),
		.step_level(o_step), .dir_up(o_dir), .motor_released(o_rel),
		.fsm_state(o_state), .stop_reason(o_reason), .pulses_done(o_done),
		.error_raised(o_err)
	);

	assign got = {o_status, o_step, o_dir, o_rel, o_state, o_reason, o_done, o_err};

	always #10 clk = ~clk;

	// sequencer mirror
	logic [15:0] m_maxf, m_autof, m_napmax;
	logic [7:0]  m_setup;
	logic [2:0]  m_ph, m_reason;
	logic        m_up, m_step, m_expect, m_rel, m_armed;
	logic [15:0] m_target, m_done;
	logic [18:0] m_hp, m_tick;
	logic [31:0] m_dir_ready, m_hold_dl;

	cmd_t  pending[$];
	resp_t expected_resp[$];
	int    fails = 0;
	bit    long_hold = 1'b0;
	bit    long_done = 1'b0;
	logic [31:0] ms_now = 32'd100;

	function automatic logic [18:0] half_period(input logic [15:0] f);
		longint unsigned hp;
		hp = 64'(TIMER_TICK_HZ) / ((f == 16'd0 ? 64'd1 : 64'(f)) * 64'd2);
		if (hp == 0) hp = 1;
		if (hp > 524287) hp = 524287;
		return 19'(hp);
	endfunction

	function automatic bit reached(input logic [31:0] t, input logic [31:0] dl);
		logic [31:0] d;
		d = t - dl;
		return d[31] == 1'b0;
	endfunction

	function automatic logic [1:0] filt_err(input logic up, input cmd_t c);
		if (c.fmis) return ERR_MISMATCH;
		if (up && c.bup) return ERR_UPPER;
		if (!up && c.bdn) return ERR_LOWER;
		return ERR_NONE;
	endfunction

	function automatic void mirror_reset();
		m_maxf = 16'd2000; m_autof = 16'd500; m_napmax = 16'd200; m_setup = 8'd5;
		m_ph = PH_IDLE; m_up = 1'b1; m_target = 16'd0; m_done = 16'd0;
		m_hp = half_period(16'd500); m_tick = 19'd0; m_step = 1'b0; m_expect = 1'b0;
		m_rel = 1'b0; m_reason = SR_NONE; m_dir_ready = 32'd0; m_hold_dl = 32'd0;
		m_armed = 1'b0;
	endfunction

	function automatic void halt_motion();
		m_step = 1'b0; m_tick = 19'd0; m_target = 16'd0; m_ph = PH_IDLE;
		m_armed = 1'b0; m_hold_dl = 32'd0; m_expect = 1'b0; m_reason = SR_REQUESTED;
	endfunction

	function automatic void begin_move(input cmd_t c, input logic [15:0] p,
			input logic [15:0] f, input logic ex, inout logic [2:0] s,
			inout logic [1:0] e);
		logic [1:0] fe;
		if (p == 16'd0 || f == 16'd0 || f > m_maxf) begin
			s = ST_PARAM;
			return;
		end
		if (m_ph != PH_IDLE) begin
			s = (m_ph == PH_FAULT) ? ST_INFAULT : ST_BUSY;
			return;
		end
		fe = filt_err(c.up, c);
		if (fe != ERR_NONE) begin
			e = fe; m_ph = PH_FAULT; s = ST_BLOCKED;
			return;
		end
		m_up = c.up; m_target = p; m_done = 16'd0; m_hp = half_period(f);
		m_tick = 19'd0; m_step = 1'b0; m_expect = ex; m_reason = SR_NONE;
		m_armed = 1'b0; m_hold_dl = 32'd0; m_rel = 1'b0;
		m_dir_ready = c.now + 32'(m_setup); m_ph = PH_DIRWAIT;
	endfunction

	function automatic void half_period_event(input logic [3:0] raw,
			inout logic [1:0] e);
		logic hit;
		hit = m_up ? (raw[0] | raw[1]) : (raw[2] | raw[3]);
		if (raw[0] != raw[1] || raw[2] != raw[3]) begin
			e = ERR_MISMATCH; m_reason = SR_MISMATCH; m_step = 1'b0; m_tick = 19'd0;
			m_expect = 1'b0; m_ph = PH_FAULT;
		end else if (hit) begin
			m_step = 1'b0; m_tick = 19'd0;
			if (m_expect) begin
				m_reason = SR_EXPECTED; m_ph = PH_HOLD;
			end else begin
				e = m_up ? ERR_UPPER : ERR_LOWER; m_reason = SR_FAULT; m_ph = PH_FAULT;
			end
			m_expect = 1'b0;
		end else if (!m_step) begin
			if (m_done >= m_target) begin
				m_step = 1'b0; m_tick = 19'd0; m_expect = 1'b0; m_reason = SR_DONE;
				m_ph = PH_HOLD;
			end else begin
				m_step = 1'b1; m_done = m_done + 16'd1;
			end
		end else begin
			m_step = 1'b0;
			if (m_done >= m_target) begin
				m_tick = 19'd0; m_expect = 1'b0; m_reason = SR_DONE; m_ph = PH_HOLD;
			end
		end
	endfunction

	function automatic resp_t predict_step(input cmd_t c);
		resp_t r;
		logic [2:0] s;
		logic [1:0] e, fe;
		s = ST_OK; e = ERR_NONE;
		case (c.req)
			REQ_START_FIN: begin_move(c, c.pulses, c.freq, 1'b0, s, e);
			REQ_START_LIM: begin_move(c, c.pulses, c.freq, 1'b1, s, e);
			REQ_NAP: begin
				if (c.pulses == 16'd0 || c.pulses > m_napmax) s = ST_PARAM;
				else begin_move(c, c.pulses, m_autof, 1'b0, s, e);
			end
			REQ_STOP: halt_motion();
			REQ_CLEAR: begin
				if (m_ph == PH_FAULT) begin
					m_step = 1'b0; m_tick = 19'd0; m_ph = PH_IDLE; m_reason = SR_NONE;
				end
			end
			REQ_RELEASE: begin
				halt_motion();
				m_rel = 1'b1;
			end
			REQ_HOLD: m_rel = 1'b0;
			REQ_POLL: begin
				if (m_ph == PH_DIRWAIT) begin
					if (reached(c.now, m_dir_ready)) begin
						fe = filt_err(m_up, c);
						if (fe != ERR_NONE) begin
							e = fe; m_ph = PH_FAULT;
						end else begin
							m_tick = 19'd0; m_ph = PH_RUN;
						end
					end
				end else if (m_ph == PH_HOLD) begin
					if (!m_armed) begin
						m_hold_dl = c.now + 32'(m_setup); m_armed = 1'b1;
					end
					if (reached(c.now, m_hold_dl)) begin
						m_armed = 1'b0; m_hold_dl = 32'd0; m_ph = PH_IDLE;
					end
				end
			end
			REQ_TICK: begin
				if (m_ph == PH_RUN) begin
					m_tick = m_tick + 19'd1;
					if (m_tick >= m_hp) begin
						m_tick = 19'd0;
						half_period_event(c.raw, e);
					end
				end
			end
			default: ;
		endcase
		r.status = s; r.step = m_step; r.dir = m_up; r.rel = m_rel; r.st = m_ph;
		r.reason = m_reason; r.done = m_done; r.err = e;
		return r;
	endfunction

	// item builders
	function automatic cmd_t noise_fields();
		cmd_t c;
		c.up = 1'($urandom); c.pulses = 16'($urandom); c.freq = 16'($urandom);
		c.now = $urandom; c.raw = 4'($urandom); c.fmis = 1'($urandom);
		c.bup = 1'($urandom); c.bdn = 1'($urandom); c.req = 4'($urandom);
		return c;
	endfunction

	function automatic cmd_t quiet(input logic [3:0] rq);
		cmd_t c;
		c = noise_fields();
		c.req = rq; c.now = ms_now;
		c.raw = ($urandom_range(0, 60) == 0) ? 4'($urandom) : 4'd0;
		c.fmis = ($urandom_range(0, 15) == 0); c.bup = ($urandom_range(0, 10) == 0);
		c.bdn = ($urandom_range(0, 10) == 0);
		return c;
	endfunction

	// one well-formed move: start, polls through setup, ticks, polls through hold
	task automatic queue_move();
		cmd_t c;
		int n;
		c = quiet(4'($urandom_range(0, 2)));
		c.pulses = 16'($urandom_range(1, 4));
		c.freq = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 65535))
			: 16'($urandom_range(250000, 500000) / 1000 + 1);
		if (c.req == REQ_START_LIM && $urandom_range(0, 1)) c.pulses = 16'($urandom);
		pending.push_back(c);
		for (n = 0; n < 3; n++) begin
			ms_now = ms_now + 32'($urandom_range(0, 3));
			pending.push_back(quiet(REQ_POLL));
		end
		for (n = 0; n < $urandom_range(10, 40); n++) begin
			c = quiet(REQ_TICK);
			c.raw = ($urandom_range(0, 25) == 0) ? 4'($urandom) : 4'd0;
			pending.push_back(c);
		end
		for (n = 0; n < 3; n++) begin
			ms_now = ms_now + 32'($urandom_range(0, 4));
			pending.push_back(quiet(REQ_POLL));
		end
		if ($urandom_range(0, 4) == 0) pending.push_back(quiet(REQ_STOP));
		if ($urandom_range(0, 4) == 0) pending.push_back(quiet(REQ_CLEAR));
		if ($urandom_range(0, 8) == 0)
			pending.push_back(quiet($urandom_range(0, 1) ? REQ_RELEASE : REQ_HOLD));
		if ($urandom_range(0, 6) == 0) pending.push_back(noise_fields());
	endtask

	task automatic wait_drained();
		while (pending.size() != 0 || expected_resp.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_MAX_FREQ:  m_maxf = val;
			CFG_AUTO_FREQ: m_autof = val;
			CFG_NAP_MAX:   m_napmax = val;
			default:       m_setup = val[7:0];
		endcase
	endtask

	// driver: bursts and gaps, fed from the pending queue
	int gap = 0, burst = 0;
	bit hold_sender = 1'b0;
	bit in_stall_seen = 1'b0;
	int idle_cycles = 0;
	always @(negedge clk) begin
		if (!in_valid || !in_stall_seen) begin
			if (gap > 0 || hold_sender || pending.size() == 0) begin
				in_valid <= 1'b0;
				if (gap > 0) gap <= gap - 1;
			end else begin
				cur <= pending[0];
				in_valid <= 1'b1;
				if (burst == 0) begin
					burst <= $urandom_range(1, 30);
					gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
				end else begin
					burst <= burst - 1;
				end
			end
		end
	end

	// track acceptance at the rising edge; predict there
	always @(posedge clk) begin
		in_stall_seen <= 1'b0;
		if (arst_n && in_valid) begin
			if (!in_stall)
				expected_resp.push_back(predict_step(pending.pop_front()));
			else
				in_stall_seen <= 1'b1;
		end
	end

	// receiver: own stall pattern, plus one long hold-off counted here
	int stall_len = 0;
	int long_cnt = 0;
	always @(negedge clk) begin
		if (long_hold && !long_done) begin
			out_stall <= 1'b1;
			long_cnt <= long_cnt + 1;
			if (long_cnt == 199) long_done <= 1'b1;
		end else if (stall_len > 0) begin
			out_stall <= 1'b1;
			stall_len <= stall_len - 1;
		end else if ($urandom_range(0, 9) < 2) begin
			out_stall <= 1'b1;
			stall_len <= $urandom_range(0, 4);
		end else out_stall <= 1'b0;
	end

	// monitor: compare each result beat with the oldest expectation
	always @(posedge clk) begin
		resp_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_resp.size() == 0) begin
				$display("%0t unexpected result beat %h", $time, got);
				fails++;
			end else begin
				e = expected_resp.pop_front();
				if (e.status !== got.status)
					$display("%0t status exp %0d got %0d", $time, e.status, got.status);
				if (e.step !== got.step)
					$display("%0t step_level exp %0d got %0d", $time, e.step, got.step);
				if (e.dir !== got.dir)
					$display("%0t dir_up exp %0d got %0d", $time, e.dir, got.dir);
				if (e.rel !== got.rel)
					$display("%0t motor_released exp %0d got %0d", $time, e.rel, got.rel);
				if (e.st !== got.st)
					$display("%0t fsm_state exp %0d got %0d", $time, e.st, got.st);
				if (e.reason !== got.reason)
					$display("%0t stop_reason exp %0d got %0d", $time, e.reason, got.reason);
				if (e.done !== got.done)
					$display("%0t pulses_done exp %0d got %0d", $time, e.done, got.done);
				if (e.err !== got.err)
					$display("%0t error_raised exp %0d got %0d", $time, e.err, got.err);
				if (e !== got) fails++;
			end
		end
	end

	// watchdog on cycles without any accepted or delivered beat
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 5000) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		cmd_t c;
		int k, phase_no, target;
		mirror_reset();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: errors, extremes, every request kind
		c = quiet(REQ_START_FIN); c.pulses = 16'd0; c.freq = 16'd100; pending.push_back(c);
		c = quiet(REQ_START_FIN); c.pulses = 16'd1; c.freq = 16'd0; pending.push_back(c);
		c = quiet(REQ_START_LIM); c.pulses = 16'hFFFF; c.freq = 16'hFFFF;
		pending.push_back(c);
		c = quiet(REQ_NAP); c.pulses = 16'd201; pending.push_back(c);
		c = quiet(REQ_START_FIN); c.up = 1'b1; c.pulses = 16'd1; c.freq = 16'd2000;
		c.fmis = 1'b1; pending.push_back(c);
		pending.push_back(quiet(REQ_START_FIN));
		c = quiet(REQ_CLEAR); pending.push_back(c);
		c = quiet(REQ_START_FIN); c.up = 1'b0; c.pulses = 16'd2; c.freq = 16'd2000;
		c.fmis = 1'b0; c.bup = 1'b0; c.bdn = 1'b0; pending.push_back(c);
		c.req = REQ_NAP; pending.push_back(c);
		c = quiet(REQ_POLL); c.now = ms_now + 32'd5; c.fmis = 1'b0; c.bup = 1'b0;
		c.bdn = 1'b0; pending.push_back(c);
		for (k = 0; k < 3; k++) begin
			c = quiet(REQ_TICK); c.raw = 4'd0; pending.push_back(c);
		end
		c = quiet(REQ_TICK); c.raw = 4'b0100; pending.push_back(c);
		c = quiet(4'd9); pending.push_back(c);
		c = quiet(4'hF); pending.push_back(c);
		pending.push_back(quiet(REQ_RELEASE));
		pending.push_back(quiet(REQ_HOLD));
		pending.push_back(quiet(REQ_STOP));
		wait_drained();

		// phases over several register settings, extremes included
		for (phase_no = 0; phase_no < 6; phase_no++) begin
			case (phase_no)
				0: begin
					write_reg(CFG_MAX_FREQ, 16'hFFFF); write_reg(CFG_AUTO_FREQ, 16'hFFFF);
					write_reg(CFG_NAP_MAX, 16'hFFFF); write_reg(CFG_SETUP_MS, 16'd0);
				end
				1: begin
					write_reg(CFG_MAX_FREQ, 16'd1); write_reg(CFG_AUTO_FREQ, 16'd1);
					write_reg(CFG_NAP_MAX, 16'd1); write_reg(CFG_SETUP_MS, 16'd255);
				end
				default: begin
					write_reg(CFG_MAX_FREQ, 16'($urandom_range(1000, 65535)));
					write_reg(CFG_AUTO_FREQ, 16'($urandom_range(2000, 65535)));
					write_reg(CFG_NAP_MAX, 16'($urandom_range(1, 8)));
					write_reg(CFG_SETUP_MS, 16'($urandom_range(0, 6)));
				end
			endcase
			target = 90;
			for (k = 0; k < target / 15; k++) queue_move();
			if (phase_no == 2) begin
				repeat (60) @(posedge clk);
				long_hold = 1'b1;
				wait (long_done);
				long_hold = 1'b0;
			end
			if (phase_no == 3) begin
				hold_sender = 1'b1;
				while (expected_resp.size() != 0) @(posedge clk);
				hold_sender = 1'b0;
			end
			wait_drained();
		end

		if (fails == 0) $display("ALL CHECKS PASSED");
		else $display("CHECKS FAILED");
		$finish;
	end
endmodule

// File: filelist.f
rtl/sps_pkg.sv
rtl/sps_datapath.sv
rtl/sps_ctrl.sv
rtl/stepper_pulse_sequencer_with_limits.sv
test/stepper_pulse_sequencer_with_limits_test.sv
